// ===== rtl/core/svpt_pkg.sv =====
// Shared types, widths and constants for the space vector PWM timing block.
// Every module of the block imports this package; it depends on nothing else.
package svpt_pkg;

  // Fixed-point fraction bits of the active-vector times.
  localparam int FRAC_BITS = 14;

  // Field widths.
  localparam int HW = 16;  // half period, compare counts
  localparam int UW = 15;  // bus voltage
  localparam int AW = 16;  // alpha/beta inputs

  // Internal widths, most derived from the fraction bits and the field widths.
  localparam int SW   = FRAC_BITS + 1;        // sqrt(3) constant
  localparam int PSW  = FRAC_BITS + 19;       // signed projections
  localparam int PW   = FRAC_BITS + 17;       // projection magnitudes
  localparam int MW   = SW + PW;              // sqrt(3) times projection
  localparam int NW   = MW + HW;              // first dividend
  localparam int DW   = UW + FRAC_BITS + 1;   // first divisor
  localparam int Q1W  = NW - (FRAC_BITS + 1); // raw active times
  localparam int HQW  = HW + FRAC_BITS;       // half period in fixed point
  localparam int SUMW = Q1W + 1;              // sum of raw times
  localparam int PLO  = 24;                   // low slice of a time in the rescale product
  localparam int PHI  = Q1W - PLO;            // high slice
  localparam int PROW = Q1W + HQW;            // rescale dividend
  localparam int Q2W  = HQW;                  // rescaled times
  localparam int CW   = HW + 2;               // compare counts before clamping

  localparam logic [63:0] SQRT3_Q30 = 64'd1859775393;
  localparam logic [SW-1:0] SQRT3_Q =
      SW'((SQRT3_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));

  // Sector codes.
  localparam logic [2:0] SECTOR_ZERO = 3'd0;
  localparam logic [2:0] SECTOR_1    = 3'd1;
  localparam logic [2:0] SECTOR_2    = 3'd2;
  localparam logic [2:0] SECTOR_3    = 3'd3;
  localparam logic [2:0] SECTOR_4    = 3'd4;
  localparam logic [2:0] SECTOR_5    = 3'd5;
  localparam logic [2:0] SECTOR_6    = 3'd6;

  // Register indexes.
  localparam logic REG_HALF_PERIOD = 1'b0;
  localparam logic REG_DC_BUS      = 1'b1;

  typedef struct packed {
    logic signed [AW-1:0] u_alpha;
    logic signed [AW-1:0] u_beta;
  } in_beat_t;

  typedef struct packed {
    logic [HW-1:0] phase_a_compare;
    logic [HW-1:0] phase_b_compare;
    logic [HW-1:0] phase_c_compare;
    logic [2:0]    sector_number;
    logic          overmodulated;
  } out_beat_t;

  // Live configuration; the bus voltage already has zero replaced by one.
  typedef struct packed {
    logic [HW-1:0] half_period;
    logic [UW-1:0] dc_bus;
  } cfg_t;

  typedef struct packed {
    logic          vld;
    logic [2:0]    sec;
    logic [NW-1:0] n1;
    logic [NW-1:0] n2;
  } numer_t;

  typedef struct packed {
    logic           vld;
    logic [2:0]     sec;
    logic [Q1W-1:0] t1;
    logic [Q1W-1:0] t2;
  } times_t;

  typedef struct packed {
    logic           vld;
    logic [2:0]     sec;
    logic           ov;
    logic [Q2W-1:0] t1;
    logic [Q2W-1:0] t2;
  } final_t;

  // Sign code of the three projections to sector number.
  function automatic logic [2:0] sector_of_code(input logic [2:0] code);
    logic [2:0] s;
    case (code)
      3'd1:    s = SECTOR_2;
      3'd2:    s = SECTOR_6;
      3'd3:    s = SECTOR_1;
      3'd4:    s = SECTOR_4;
      3'd5:    s = SECTOR_3;
      3'd6:    s = SECTOR_5;
      default: s = SECTOR_ZERO;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/core/svpt_regs.sv =====
// APB-style register file holding the half period and the bus voltage.
// Depends on svpt_pkg for the register indexes and the configuration struct.
module svpt_regs import svpt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [HW-1:0] half_period_q;
  logic [UW-1:0] dc_bus_q;
  logic          wr_en;
  logic          idx;

  assign pready = 1'b1;
  assign idx    = paddr[2];
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HW'(4000);
      dc_bus_q      <= UW'(12000);
    end else if (wr_en) begin
      case (idx)
        REG_HALF_PERIOD: half_period_q <= pwdata[HW-1:0];
        REG_DC_BUS:      dc_bus_q      <= pwdata[UW-1:0];
        default:         half_period_q <= half_period_q;
      endcase
    end
  end

  // Read data.
  always_comb begin
    case (idx)
      REG_HALF_PERIOD: prdata = {{(32-HW){1'b0}}, half_period_q};
      REG_DC_BUS:      prdata = {{(32-UW){1'b0}}, dc_bus_q};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o.half_period = half_period_q;
  assign cfg_o.dc_bus      = (dc_bus_q == '0) ? UW'(1) : dc_bus_q;

endmodule

// ===== rtl/core/svpt_front.sv =====
// Front stages: projections, sector decode, selection of the two active
// projections and the products that form the time dividends. Uses svpt_pkg.
module svpt_front import svpt_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  in_beat_t      data_i,
  input  logic [HW-1:0] half_period_i,
  output numer_t        numer_o
);

  logic                  v0_q, v1_q, v2_q, v3_q;
  logic signed [PSW-1:0] sa_q;
  logic signed [AW-1:0]  ub_q;
  logic [2:0]            sec1_q, sec2_q, sec3_q;
  logic [PW-1:0]         p1_q, p2_q;
  logic [PW-1:0]         p1_d, p2_d;
  logic [2:0]            sec1_d;
  logic [MW-1:0]         m1_q, m2_q;
  logic [NW-1:0]         n1_q, n2_q;

  function automatic logic [PW-1:0] mag(input logic signed [PSW-1:0] v);
    logic [PSW-1:0] m;
    m = (v < 0) ? PSW'(-v) : PSW'(v);
    return m[PW-1:0];
  endfunction

  // Valid bits of the four front stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage 0: sqrt(3) times alpha.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sa_q <= PSW'(data_i.u_alpha) * $signed(PSW'(SQRT3_Q));
      ub_q <= data_i.u_beta;
    end
  end

  // Stage 1: sign code, sector and the two projections it selects.
  always_comb begin
    logic signed [PSW-1:0] ubx, ubs, bs, cs, px, py, pz, pa, pb;
    logic [2:0]            code;
    ubx  = PSW'(ub_q);
    ubs  = ubx <<< FRAC_BITS;
    px   = ubx <<< (FRAC_BITS + 1);
    bs   = sa_q - ubs;
    cs   = -sa_q - ubs;
    py   = sa_q + ubs;
    pz   = ubs - sa_q;
    code = {cs > 0, bs > 0, ub_q > 0};
    sec1_d = sector_of_code(code);
    case (sec1_d)
      SECTOR_1: begin pa = pz; pb = px; end
      SECTOR_2: begin pa = pz; pb = py; end
      SECTOR_3: begin pa = px; pb = py; end
      SECTOR_4: begin pa = px; pb = pz; end
      SECTOR_5: begin pa = py; pb = pz; end
      SECTOR_6: begin pa = py; pb = px; end
      default:  begin pa = '0; pb = '0; end
    endcase
    p1_d = mag(pa);
    p2_d = mag(pb);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sec1_q <= sec1_d;
      p1_q   <= p1_d;
      p2_q   <= p2_d;
    end
  end

  // Stage 2: scale by sqrt(3).
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sec2_q <= sec1_q;
      m1_q   <= MW'(SQRT3_Q) * MW'(p1_q);
      m2_q   <= MW'(SQRT3_Q) * MW'(p2_q);
    end
  end

  // Stage 3: scale by the half period.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sec3_q <= sec2_q;
      n1_q   <= NW'(m1_q) * NW'(half_period_i);
      n2_q   <= NW'(m2_q) * NW'(half_period_i);
    end
  end

  assign numer_o.vld = v3_q;
  assign numer_o.sec = sec3_q;
  assign numer_o.n1  = n1_q;
  assign numer_o.n2  = n2_q;

endmodule

// ===== rtl/core/svpt_tdiv.sv =====
// Pipelined restoring divider, one quotient bit per stage, that turns the two
// dividends into raw active times by the scaled bus voltage. Uses svpt_pkg.
module svpt_tdiv import svpt_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [UW-1:0] dc_bus_i,
  input  numer_t        numer_i,
  output times_t        times_o
);

  logic [DW-1:0]  div;
  logic           vld_q  [Q1W];
  logic [2:0]     sec_q  [Q1W];
  logic [DW-1:0]  rem1_q [Q1W];
  logic [DW-1:0]  rem2_q [Q1W];
  logic [Q1W-1:0] sh1_q  [Q1W];
  logic [Q1W-1:0] sh2_q  [Q1W];
  logic [DW-1:0]  rem1_d [Q1W];
  logic [DW-1:0]  rem2_d [Q1W];
  logic [Q1W-1:0] sh1_d  [Q1W];
  logic [Q1W-1:0] sh2_d  [Q1W];

  assign div = {dc_bus_i, {(FRAC_BITS + 1){1'b0}}};

  // One subtract-and-compare per stage and lane.
  always_comb begin
    logic [DW-1:0]  r1, r2;
    logic [Q1W-1:0] s1, s2;
    logic [DW:0]    tr1, tr2;
    for (int k = 0; k < Q1W; k++) begin
      if (k == 0) begin
        r1 = DW'(numer_i.n1[NW-1:Q1W]);
        r2 = DW'(numer_i.n2[NW-1:Q1W]);
        s1 = numer_i.n1[Q1W-1:0];
        s2 = numer_i.n2[Q1W-1:0];
      end else begin
        r1 = rem1_q[k-1];
        r2 = rem2_q[k-1];
        s1 = sh1_q[k-1];
        s2 = sh2_q[k-1];
      end
      tr1 = {r1, s1[Q1W-1]};
      tr2 = {r2, s2[Q1W-1]};
      if (tr1 >= {1'b0, div}) begin
        rem1_d[k] = DW'(tr1 - {1'b0, div});
        sh1_d[k]  = {s1[Q1W-2:0], 1'b1};
      end else begin
        rem1_d[k] = tr1[DW-1:0];
        sh1_d[k]  = {s1[Q1W-2:0], 1'b0};
      end
      if (tr2 >= {1'b0, div}) begin
        rem2_d[k] = DW'(tr2 - {1'b0, div});
        sh2_d[k]  = {s2[Q1W-2:0], 1'b1};
      end else begin
        rem2_d[k] = tr2[DW-1:0];
        sh2_d[k]  = {s2[Q1W-2:0], 1'b0};
      end
    end
  end

  // Valid bits travel with the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Q1W; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= numer_i.vld;
      for (int k = 1; k < Q1W; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // Stage data.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sec_q[0] <= numer_i.sec;
      for (int k = 1; k < Q1W; k++) sec_q[k] <= sec_q[k-1];
      for (int k = 0; k < Q1W; k++) begin
        rem1_q[k] <= rem1_d[k];
        rem2_q[k] <= rem2_d[k];
        sh1_q[k]  <= sh1_d[k];
        sh2_q[k]  <= sh2_d[k];
      end
    end
  end

  assign times_o.vld = vld_q[Q1W-1];
  assign times_o.sec = sec_q[Q1W-1];
  assign times_o.t1  = sh1_q[Q1W-1];
  assign times_o.t2  = sh2_q[Q1W-1];

endmodule

// ===== rtl/core/svpt_rescale.sv =====
// Overmodulation check and proportional rescale of the two active times:
// split products, then a pipelined divider by their sum. Uses svpt_pkg.
module svpt_rescale import svpt_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [HW-1:0] half_period_i,
  input  times_t        times_i,
  output final_t        final_o
);

  logic [HQW-1:0]     hq;
  // First stage: sum, flag and partial products.
  logic               v0_q, v1_q;
  logic [2:0]         sec0_q, sec1_q;
  logic               ov0_q, ov1_q;
  logic [SUMW-1:0]    sum0_q, sum1_q;
  logic [Q2W-1:0]     t1l0_q, t2l0_q, t1l1_q, t2l1_q;
  logic [PLO+HQW-1:0] pl1_q, pl2_q;
  logic [PHI+HQW-1:0] ph1_q, ph2_q;
  logic [PROW-1:0]    n1_q, n2_q;
  logic [SUMW-1:0]    sum_d;
  // Divider stages.
  logic               vld_q  [Q2W];
  logic [2:0]         sec_q  [Q2W];
  logic               ov_q   [Q2W];
  logic [SUMW-1:0]    sum_q  [Q2W];
  logic [Q2W-1:0]     t1l_q  [Q2W];
  logic [Q2W-1:0]     t2l_q  [Q2W];
  logic [SUMW-1:0]    rem1_q [Q2W];
  logic [SUMW-1:0]    rem2_q [Q2W];
  logic [Q2W-1:0]     sh1_q  [Q2W];
  logic [Q2W-1:0]     sh2_q  [Q2W];
  logic [SUMW-1:0]    rem1_d [Q2W];
  logic [SUMW-1:0]    rem2_d [Q2W];
  logic [Q2W-1:0]     sh1_d  [Q2W];
  logic [Q2W-1:0]     sh2_d  [Q2W];

  assign hq    = {half_period_i, {FRAC_BITS{1'b0}}};
  assign sum_d = SUMW'(times_i.t1) + SUMW'(times_i.t2);

  // Control bits of the two product stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= times_i.vld;
      v1_q <= v0_q;
    end
  end

  // Sum, overmodulation flag and the partial products of each time.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sec0_q <= times_i.sec;
      ov0_q  <= (times_i.sec != SECTOR_ZERO) && (sum_d > SUMW'(hq));
      sum0_q <= sum_d;
      t1l0_q <= times_i.t1[Q2W-1:0];
      t2l0_q <= times_i.t2[Q2W-1:0];
      pl1_q  <= (PLO+HQW)'(times_i.t1[PLO-1:0]) * (PLO+HQW)'(hq);
      pl2_q  <= (PLO+HQW)'(times_i.t2[PLO-1:0]) * (PLO+HQW)'(hq);
      ph1_q  <= (PHI+HQW)'(times_i.t1[Q1W-1:PLO]) * (PHI+HQW)'(hq);
      ph2_q  <= (PHI+HQW)'(times_i.t2[Q1W-1:PLO]) * (PHI+HQW)'(hq);
    end
  end

  // Partial products joined into the full dividends.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sec1_q <= sec0_q;
      ov1_q  <= ov0_q;
      sum1_q <= sum0_q;
      t1l1_q <= t1l0_q;
      t2l1_q <= t2l0_q;
      n1_q   <= (PROW'(ph1_q) << PLO) + PROW'(pl1_q);
      n2_q   <= (PROW'(ph2_q) << PLO) + PROW'(pl2_q);
    end
  end

  // One quotient bit per stage; the divisor travels with the item.
  always_comb begin
    logic [SUMW-1:0] r1, r2, dv;
    logic [Q2W-1:0]  s1, s2;
    logic [SUMW:0]   tr1, tr2;
    for (int k = 0; k < Q2W; k++) begin
      if (k == 0) begin
        r1 = SUMW'(n1_q[PROW-1:Q2W]);
        r2 = SUMW'(n2_q[PROW-1:Q2W]);
        s1 = n1_q[Q2W-1:0];
        s2 = n2_q[Q2W-1:0];
        dv = sum1_q;
      end else begin
        r1 = rem1_q[k-1];
        r2 = rem2_q[k-1];
        s1 = sh1_q[k-1];
        s2 = sh2_q[k-1];
        dv = sum_q[k-1];
      end
      tr1 = {r1, s1[Q2W-1]};
      tr2 = {r2, s2[Q2W-1]};
      if (tr1 >= {1'b0, dv}) begin
        rem1_d[k] = SUMW'(tr1 - {1'b0, dv});
        sh1_d[k]  = {s1[Q2W-2:0], 1'b1};
      end else begin
        rem1_d[k] = tr1[SUMW-1:0];
        sh1_d[k]  = {s1[Q2W-2:0], 1'b0};
      end
      if (tr2 >= {1'b0, dv}) begin
        rem2_d[k] = SUMW'(tr2 - {1'b0, dv});
        sh2_d[k]  = {s2[Q2W-2:0], 1'b1};
      end else begin
        rem2_d[k] = tr2[SUMW-1:0];
        sh2_d[k]  = {s2[Q2W-2:0], 1'b0};
      end
    end
  end

  // Valid bits of the divider stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Q2W; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= v1_q;
      for (int k = 1; k < Q2W; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // Divider stage data.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sec_q[0] <= sec1_q;
      ov_q[0]  <= ov1_q;
      sum_q[0] <= sum1_q;
      t1l_q[0] <= t1l1_q;
      t2l_q[0] <= t2l1_q;
      for (int k = 1; k < Q2W; k++) begin
        sec_q[k] <= sec_q[k-1];
        ov_q[k]  <= ov_q[k-1];
        sum_q[k] <= sum_q[k-1];
        t1l_q[k] <= t1l_q[k-1];
        t2l_q[k] <= t2l_q[k-1];
      end
      for (int k = 0; k < Q2W; k++) begin
        rem1_q[k] <= rem1_d[k];
        rem2_q[k] <= rem2_d[k];
        sh1_q[k]  <= sh1_d[k];
        sh2_q[k]  <= sh2_d[k];
      end
    end
  end

  // Without overmodulation the times already fit below the half period.
  assign final_o.vld = vld_q[Q2W-1];
  assign final_o.sec = sec_q[Q2W-1];
  assign final_o.ov  = ov_q[Q2W-1];
  assign final_o.t1  = ov_q[Q2W-1] ? sh1_q[Q2W-1] : t1l_q[Q2W-1];
  assign final_o.t2  = ov_q[Q2W-1] ? sh2_q[Q2W-1] : t2l_q[Q2W-1];

endmodule

// ===== rtl/core/svpt_counts.sv =====
// Compare counts from the final times, clamped and permuted per sector, into
// the output register. Uses svpt_pkg for widths, sector codes and beat type.
module svpt_counts import svpt_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [HW-1:0] half_period_i,
  input  final_t        final_i,
  output logic          valid_o,
  output out_beat_t     data_o
);

  logic [HQW-1:0] hq, diff;
  logic [CW-1:0]  c1_d, c2_d, c3_d;
  logic           v0_q, v1_q;
  logic [2:0]     sec_q;
  logic           ov_q;
  logic [CW-1:0]  c1_q, c2_q, c3_q;
  out_beat_t      out_d, out_q;

  function automatic logic [HW-1:0] clamp(input logic [CW-1:0] c, input logic [HW-1:0] h);
    return (c > CW'(h)) ? h : c[HW-1:0];
  endfunction

  assign hq   = {half_period_i, {FRAC_BITS{1'b0}}};
  assign diff = hq - final_i.t1 - final_i.t2;
  assign c1_d = CW'(diff >> (FRAC_BITS + 1));
  assign c2_d = c1_d + CW'(final_i.t1 >> FRAC_BITS);
  assign c3_d = c2_d + CW'(final_i.t2 >> FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= final_i.vld;
      v1_q <= v0_q;
    end
  end

  // Raw counts.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sec_q <= final_i.sec;
      ov_q  <= final_i.ov;
      c1_q  <= c1_d;
      c2_q  <= c2_d;
      c3_q  <= c3_d;
    end
  end

  // Clamp and route the counts to the phases.
  always_comb begin
    logic [HW-1:0] a, b, c;
    a = clamp(c1_q, half_period_i);
    b = clamp(c2_q, half_period_i);
    c = clamp(c3_q, half_period_i);
    out_d.sector_number = sec_q;
    out_d.overmodulated = ov_q;
    case (sec_q)
      SECTOR_1: begin
        out_d.phase_a_compare = a; out_d.phase_b_compare = b; out_d.phase_c_compare = c;
      end
      SECTOR_2: begin
        out_d.phase_a_compare = b; out_d.phase_b_compare = a; out_d.phase_c_compare = c;
      end
      SECTOR_3: begin
        out_d.phase_a_compare = c; out_d.phase_b_compare = a; out_d.phase_c_compare = b;
      end
      SECTOR_4: begin
        out_d.phase_a_compare = c; out_d.phase_b_compare = b; out_d.phase_c_compare = a;
      end
      SECTOR_5: begin
        out_d.phase_a_compare = b; out_d.phase_b_compare = c; out_d.phase_c_compare = a;
      end
      SECTOR_6: begin
        out_d.phase_a_compare = a; out_d.phase_b_compare = c; out_d.phase_c_compare = b;
      end
      default: begin
        out_d.phase_a_compare = half_period_i >> 1;
        out_d.phase_b_compare = half_period_i >> 1;
        out_d.phase_c_compare = half_period_i >> 1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) out_q <= out_d;
  end

  assign valid_o = v1_q;
  assign data_o  = out_q;

endmodule

// ===== rtl/core/space_vector_pwm_timing.sv =====
// Top level of the space vector PWM timing block: register port and pipeline.
// Depends on svpt_pkg, svpt_regs, svpt_front, svpt_tdiv, svpt_rescale, svpt_counts.
//
//   Channel   Valid        Stall        Payload
//   input     in_valid_i   in_stall_o   in_data_i  (in_beat_t)
//   output    out_valid_o  out_stall_i  out_data_o (out_beat_t)
//   config    psel/penable pready=1     paddr, pwdata, prdata
//
// One vector is taken per cycle while the output does not stall; each result passes
// through 4 front stages, 47 stages of the time divider, 2 product stages,
// 30 stages of the rescale divider and 2 count stages.
// Reset clears all valid bits and loads the register defaults.
// A stalled output beat holds the whole pipeline, so the input stalls with it.
module space_vector_pwm_timing import svpt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_beat_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_beat_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t   cfg;
  numer_t numer;
  times_t times;
  final_t fin;
  logic   en;

  // The pipeline moves unless a finished beat waits at the output.
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  svpt_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  svpt_front u_front (
    .clk_i, .rst_ni,
    .en_i          (en),
    .valid_i       (in_valid_i),
    .data_i        (in_data_i),
    .half_period_i (cfg.half_period),
    .numer_o       (numer)
  );

  svpt_tdiv u_tdiv (
    .clk_i, .rst_ni,
    .en_i     (en),
    .dc_bus_i (cfg.dc_bus),
    .numer_i  (numer),
    .times_o  (times)
  );

  svpt_rescale u_rescale (
    .clk_i, .rst_ni,
    .en_i          (en),
    .half_period_i (cfg.half_period),
    .times_i       (times),
    .final_o       (fin)
  );

  svpt_counts u_counts (
    .clk_i, .rst_ni,
    .en_i          (en),
    .half_period_i (cfg.half_period),
    .final_i       (fin),
    .valid_o       (out_valid_o),
    .data_o        (out_data_o)
  );

endmodule

// ===== rtl/core/svpt_checker.sv =====
// Port-level checks of the space vector PWM timing block, bound to the top.
// Depends on svpt_pkg for the beat types and sector codes.
module svpt_checker import svpt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_beat_t   out_data_o
);

  // A stalled output beat stays and holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  // A waiting output beat holds the input side back.
  a_back_pressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output beat waits");

  // The zero vector gives three equal counts and no flag.
  a_zero_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.sector_number == SECTOR_ZERO |->
      out_data_o.phase_a_compare == out_data_o.phase_b_compare &&
      out_data_o.phase_b_compare == out_data_o.phase_c_compare &&
      !out_data_o.overmodulated)
    else $error("zero vector counts differ");

  // Sector numbers stay within one to six or zero.
  a_sector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.sector_number != 3'd7)
    else $error("sector number out of range");

endmodule

bind space_vector_pwm_timing svpt_checker u_svpt_checker (.*);
